[rtl/isms_pkg.sv]
// Shared types, widths and constants for the interval schedule counter.
// Used by every module of the block but isms_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package isms_pkg;

    localparam int MAX_INTERVALS = 64;
    localparam int ADDR_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    localparam int HOUR_W = 5;
    localparam int MIN_W = 6;
    localparam int DUR_W = 12;
    localparam int GAP_W = 6;
    localparam int START_W = 11;
    localparam int END_W = 13;
    localparam int COUNT_W = 7;

    localparam logic [GAP_W-1:0] GAP_RESET = 6'd10;
    localparam logic [START_W-1:0] MINUTES_PER_HOUR = 11'd60;

    localparam int COUNT_MAX = 127;
    localparam int SAT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SEL_LIMIT = (MAX_INTERVALS < COUNT_MAX) ? MAX_INTERVALS : COUNT_MAX;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [START_W-1:0] start_min;
        logic [END_W-1:0]   end_min;
    } entry_t;

    localparam int ENTRY_W = START_W + END_W;

    typedef struct packed {
        entry_t iv;
        logic   last;
    } item_t;

    // Order by end time, ties by start time.
    function automatic logic goes_before(entry_t a, entry_t b);
        return (a.end_min < b.end_min) ||
               ((a.end_min == b.end_min) && (a.start_min < b.start_min));
    endfunction

endpackage

`default_nettype wire

[rtl/interval_schedule_max_count.sv]
// Top level of the interval schedule counter: front end, queue and back end.
// Depends on isms_pkg, isms_front, isms_queue, isms_back.
//
// Intervals arrive on a queue-style input: an item transfers when push is high
// and full is low. Each gives a start hour, start minute and duration; the
// front end turns it into start and end minutes (end includes the gap held in
// the configuration register, written through cfg_valid/cfg_ready/cfg_data).
// A four-entry queue lets the input take one item per cycle while the back
// end sorts, as long as the queue is not full. The back end inserts each
// interval into a 64-entry RAM kept in end-time order, one shift per cycle.
// After the item marked last, a greedy scan reads the RAM once; from the done
// state the count moves to the result side once that side is empty. The
// result waits while empty is low until pop transfers it; while it waits, a
// further set is loaded but its result is held back. Reset empties the queue
// and the store, clears the overflow flag and sets the gap to 10 minutes; the
// store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module interval_schedule_max_count (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [isms_pkg::HOUR_W-1:0]   start_hour,
    input  wire logic [isms_pkg::MIN_W-1:0]    start_minute,
    input  wire logic [isms_pkg::DUR_W-1:0]    duration_minutes,
    input  wire logic                          last_item,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [isms_pkg::COUNT_W-1:0]       selected_count,
    output logic                               overflow,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [isms_pkg::GAP_W-1:0]    cfg_data
);
    import isms_pkg::*;

    logic  q_push;
    logic  q_full;
    item_t q_wr_item;
    logic  q_pop;
    logic  q_empty;
    item_t q_rd_item;

    isms_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .start_hour       (start_hour),
        .start_minute     (start_minute),
        .duration_minutes (duration_minutes),
        .last_item        (last_item),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .q_push           (q_push),
        .q_item           (q_wr_item),
        .q_full           (q_full)
    );

    isms_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .empty   (q_empty)
    );

    isms_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (q_rd_item),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .selected_count (selected_count),
        .overflow       (overflow)
    );

endmodule

`default_nettype wire

[rtl/isms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module isms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/isms_front.sv]
// Front end: holds the gap register, accepts intervals and converts them to
// start and end minutes for the queue. Depends on isms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isms_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [isms_pkg::HOUR_W-1:0]    start_hour,
    input  wire logic [isms_pkg::MIN_W-1:0]     start_minute,
    input  wire logic [isms_pkg::DUR_W-1:0]     duration_minutes,
    input  wire logic                           last_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [isms_pkg::GAP_W-1:0]     cfg_data,
    output logic                                q_push,
    output isms_pkg::item_t                     q_item,
    input  wire logic                           q_full
);
    import isms_pkg::*;

    logic [GAP_W-1:0]   gap_reg;
    logic [GAP_W-1:0]   gap_next;
    logic [START_W-1:0] start_min;
    logic [END_W-1:0]   end_min;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gap_next = gap_reg;
        if (cfg_valid && cfg_ready)
        begin
            gap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= GAP_RESET;
        end
        else
        begin
            gap_reg <= gap_next;
        end
    end

    assign start_min = START_W'(START_W'(start_hour) * MINUTES_PER_HOUR)
                     + START_W'(start_minute);
    assign end_min = END_W'(start_min) + END_W'(duration_minutes) + END_W'(gap_reg);

    assign full = q_full;
    assign q_push = push && !q_full;
    assign q_item.iv.start_min = start_min;
    assign q_item.iv.end_min = end_min;
    assign q_item.last = last_item;

endmodule

`default_nettype wire

[rtl/isms_queue.sv]
// Short first-in first-out queue of converted intervals between the front
// end and the back end. Depends on isms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isms_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire isms_pkg::item_t wr_item,
    output logic               full,
    input  wire logic          pop,
    output isms_pkg::item_t    rd_item,
    output logic               empty
);
    import isms_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/isms_back.sv]
// Back end: keeps the stored intervals sorted by insertion, runs the greedy
// scan after the last item and holds the result. Depends on isms_pkg, isms_ram.
`timescale 1ns / 1ps
`default_nettype none

module isms_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire isms_pkg::item_t               q_item,
    output logic                               q_pop,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [isms_pkg::COUNT_W-1:0]       selected_count,
    output logic                               overflow
);
    import isms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_START,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [ADDR_W-1:0]  j_reg;
    logic [ADDR_W-1:0]  j_next;
    entry_t             key_reg;
    entry_t             key_next;
    logic               last_reg;
    logic               last_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [ADDR_W-1:0]  idx_reg;
    logic [ADDR_W-1:0]  idx_next;
    logic [END_W-1:0]   last_end_reg;
    logic [END_W-1:0]   last_end_next;
    logic [CNT_W-1:0]   taken_reg;
    logic [CNT_W-1:0]   taken_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_count_next;
    logic               out_ovf_reg;
    logic               out_ovf_next;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    entry_t             wdata;
    logic [ADDR_W-1:0]  raddr;
    logic [ENTRY_W-1:0] rdata;
    entry_t             rd_entry;
    logic [SAT_W-1:0]   taken_ext;
    logic [COUNT_W-1:0] taken_sat;

    isms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_entry = entry_t'(rdata);
    assign taken_ext = SAT_W'(taken_reg);
    assign taken_sat = (taken_ext > SAT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                       : taken_ext[COUNT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next = j_reg;
        key_next = key_reg;
        last_next = last_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        last_end_next = last_end_reg;
        taken_next = taken_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_ovf_next = out_ovf_reg;
        q_pop = 1'b0;
        we = 1'b0;
        waddr = '0;
        wdata = key_reg;
        raddr = '0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    key_next = q_item.iv;
                    last_next = q_item.last;
                    if (count_reg == CNT_W'(MAX_INTERVALS))
                    begin
                        ovf_next = 1'b1;
                        state_next = q_item.last ? S_START : S_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        we = 1'b1;
                        waddr = '0;
                        wdata = q_item.iv;
                        count_next = CNT_W'(1);
                        state_next = q_item.last ? S_START : S_IDLE;
                    end
                    else
                    begin
                        j_next = count_reg[ADDR_W-1:0];
                        raddr = count_reg[ADDR_W-1:0] - ADDR_W'(1);
                        state_next = S_INS;
                    end
                end
            end
            S_INS:
            begin
                we = 1'b1;
                waddr = j_reg;
                if (goes_before(key_reg, rd_entry))
                begin
                    wdata = rd_entry;
                    j_next = j_reg - ADDR_W'(1);
                    if (j_reg == ADDR_W'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        raddr = j_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    wdata = key_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = last_reg ? S_START : S_IDLE;
                end
            end
            S_PUT:
            begin
                we = 1'b1;
                waddr = '0;
                wdata = key_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = last_reg ? S_START : S_IDLE;
            end
            S_START:
            begin
                raddr = '0;
                idx_next = '0;
                last_end_next = '0;
                taken_next = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_end_reg <= END_W'(rd_entry.start_min))
                begin
                    last_end_next = rd_entry.end_min;
                    taken_next = taken_reg + CNT_W'(1);
                end
                if (CNT_W'(idx_reg) == count_reg - CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                    raddr = idx_reg + ADDR_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = taken_sat;
                    out_ovf_next = ovf_reg;
                    count_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            j_reg <= '0;
            key_reg <= '0;
            last_reg <= 1'b0;
            ovf_reg <= 1'b0;
            idx_reg <= '0;
            last_end_reg <= '0;
            taken_reg <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            j_reg <= j_next;
            key_reg <= key_next;
            last_reg <= last_next;
            ovf_reg <= ovf_next;
            idx_reg <= idx_next;
            last_end_reg <= last_end_next;
            taken_reg <= taken_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            out_ovf_reg <= out_ovf_next;
        end
    end

    assign empty = !out_valid_reg;
    assign selected_count = out_count_reg;
    assign overflow = out_ovf_reg;

endmodule

`default_nettype wire

[rtl/isms_checker.sv]
// Port-level checks for the interval schedule counter, bound to the top level.
// Depends on isms_pkg and interval_schedule_max_count.
`timescale 1ns / 1ps
`default_nettype none

module isms_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          push,
    input wire logic                          full,
    input wire logic                          empty,
    input wire logic                          pop,
    input wire logic [isms_pkg::COUNT_W-1:0]  selected_count,
    input wire logic                          overflow,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);
    import isms_pkg::*;

    // A waiting result stays put until its transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(selected_count) && $stable(overflow)))
        else $error("result changed or vanished before its transfer");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (selected_count <= COUNT_W'(SEL_LIMIT)))
        else $error("selected_count exceeds the number of storable intervals");

    // The result slot is empty in the cycle after a transfer.
    a_slot_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty)
        else $error("result slot refilled in the cycle of its transfer");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> (empty && cfg_ready))
        else $error("result side not empty or config port not ready in reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid || push || full) |-> cfg_ready)
        else $error("config port refused a transfer");

endmodule

bind interval_schedule_max_count isms_checker u_isms_checker (.*);

`default_nettype wire
